// ===== rtl/core/dots_pkg.sv =====
// Shared types, codes and the sort-order function of the stable sprite sorter.
package dots_pkg;

  localparam logic [1:0] MODE_BACK_TO_FRONT = 2'd0;
  localparam logic [1:0] MODE_FRONT_TO_BACK = 2'd1;
  localparam logic [1:0] MODE_TEXTURE       = 2'd2;
  localparam logic [1:0] MODE_NONE          = 2'd3;

  localparam logic [1:0] PURP_NONE = 2'd0;
  localparam logic [1:0] PURP_CUR  = 2'd1;
  localparam logic [1:0] PURP_CMP  = 2'd2;
  localparam logic [1:0] PURP_OUT  = 2'd3;

  localparam logic RD_SRC_CTRL  = 1'b0;
  localparam logic RD_SRC_ORDER = 1'b1;

  typedef struct packed {
    logic signed [31:0] depth_key;
    logic [15:0]        texture_number;
    logic [15:0]        record_tag;
    logic               batch_last;
  } in_t;

  typedef struct packed {
    logic [15:0]        out_tag;
    logic signed [31:0] out_depth;
    logic [15:0]        out_texture;
    logic               out_last;
    logic               overflow_flag;
  } out_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic [15:0]        texture;
    logic [15:0]        tag;
  } rec_t;

  typedef struct packed {
    logic       wr;
    logic       rd_en;
    logic       rd_src;
    logic [1:0] purp;
    logic       ord_wr;
    logic       ord_rd;
    logic       out_ld;
    logic       out_last;
    logic       out_ovf;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

  function automatic logic goes_before(logic [1:0] mode, rec_t a, rec_t b);
    logic res;
    case (mode)
      MODE_BACK_TO_FRONT: res = ($signed(a.depth) > $signed(b.depth));
      MODE_FRONT_TO_BACK: res = ($signed(a.depth) < $signed(b.depth));
      MODE_TEXTURE:       res = (a.texture < b.texture);
      MODE_NONE:          res = 1'b0;
      default:            res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/core/dots_ctrl.sv =====
// Controller of the sprite sorter: load, rank scan and emission sequencing.
module dots_ctrl import dots_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  localparam int IW = $clog2(MAX_RECORDS),
  localparam int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  output logic          in_stall_o,
  input  sts_t          sts_i,
  output cmd_t          cmd_o,
  output logic [IW-1:0] addr_o,
  output logic [IW-1:0] cur_idx_o
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_RD_I  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_WR    = 3'd4;
  localparam logic [2:0] ST_O_RD  = 3'd5;
  localparam logic [2:0] ST_O_REC = 3'd6;
  localparam logic [2:0] ST_O_LD  = 3'd7;

  localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);

  logic [2:0]    state_q, state_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] last_idx;
  logic          in_acc;

  assign last_idx  = IW'(fill_q - CW'(1));
  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc    = in_valid_i && !in_stall_o;
  assign cur_idx_o = i_q;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    cmd_o   = '0;
    addr_o  = '0;
    case (state_q)
      ST_LOAD: begin
        addr_o = fill_q[IW-1:0];
        if (in_acc) begin
          if (fill_q < CAP) begin
            cmd_o.wr = 1'b1;
            fill_d   = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            i_d     = '0;
            state_d = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_SRC_CTRL;
        cmd_o.purp   = PURP_CUR;
        addr_o       = i_q;
        j_d          = '0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_SRC_CTRL;
        cmd_o.purp   = PURP_CMP;
        addr_o       = j_q;
        j_d          = j_q + IW'(1);
        if (j_q == last_idx) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        cmd_o.ord_wr = 1'b1;
        if (i_q == last_idx) begin
          k_d     = '0;
          state_d = ST_O_RD;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_RD_I;
        end
      end
      ST_O_RD: begin
        cmd_o.ord_rd = 1'b1;
        addr_o       = k_q;
        state_d      = ST_O_REC;
      end
      ST_O_REC: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_src = RD_SRC_ORDER;
        cmd_o.purp   = PURP_OUT;
        state_d      = ST_O_LD;
      end
      ST_O_LD: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld   = 1'b1;
          cmd_o.out_last = (k_q == last_idx);
          cmd_o.out_ovf  = ovf_q;
          if (k_q == last_idx) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = ST_O_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ===== rtl/core/dots_dpath.sv =====
// Datapath of the sprite sorter: record store, rank counter, order store, output register.
module dots_dpath import dots_pkg::*; #(
  parameter int MAX_RECORDS = 64,
  localparam int IW = $clog2(MAX_RECORDS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  in_t           in_data_i,
  input  cmd_t          cmd_i,
  input  logic [IW-1:0] addr_i,
  input  logic [IW-1:0] cur_idx_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output out_t          out_data_o
);

  rec_t          store [MAX_RECORDS];
  logic [IW-1:0] ord_mem [MAX_RECORDS];

  logic [1:0]    mode_q;
  rec_t          rdata_q;
  rec_t          cur_q;
  logic [IW-1:0] ord_rdata_q;
  logic [IW-1:0] cmp_j_q;
  logic [IW-1:0] rank_q;
  logic          cur_pend_q;
  logic          cmp_pend_q;
  logic          out_valid_q;
  out_t          out_q;
  logic [IW-1:0] raddr;
  rec_t          wrec;
  logic          ahead;

  assign raddr = (cmd_i.rd_src == RD_SRC_ORDER) ? ord_rdata_q : addr_i;

  always_comb begin
    wrec.depth   = in_data_i.depth_key;
    wrec.texture = in_data_i.texture_number;
    wrec.tag     = in_data_i.record_tag;
  end

  assign ahead = goes_before(mode_q, rdata_q, cur_q) ||
                 (!goes_before(mode_q, cur_q, rdata_q) && (cmp_j_q < cur_idx_i));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store[addr_i] <= wrec;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ord_wr) begin
      ord_mem[rank_q] <= cur_idx_i;
    end
    if (cmd_i.ord_rd) begin
      ord_rdata_q <= ord_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en && (cmd_i.purp == PURP_CMP)) begin
      cmp_j_q <= addr_i;
    end
    if (cur_pend_q) begin
      cur_q  <= rdata_q;
      rank_q <= '0;
    end else if (cmp_pend_q && ahead) begin
      rank_q <= rank_q + IW'(1);
    end
    if (cmd_i.out_ld) begin
      out_q.out_tag       <= rdata_q.tag;
      out_q.out_depth     <= rdata_q.depth;
      out_q.out_texture   <= rdata_q.texture;
      out_q.out_last      <= cmd_i.out_last;
      out_q.overflow_flag <= cmd_i.out_ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_BACK_TO_FRONT;
      cur_pend_q  <= 1'b0;
      cmp_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      cur_pend_q <= cmd_i.rd_en && (cmd_i.purp == PURP_CUR);
      cmp_pend_q <= cmd_i.rd_en && (cmd_i.purp == PURP_CMP);
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== rtl/core/depth_or_texture_stable_sorter.sv =====
// Top level of the stable sprite sorter.
// Input channel: sprite records (depth, texture, tag, batch_last), one transaction per
// record. While a batch loads, in_stall_o is low and a record is taken every cycle.
// The record that carries batch_last starts the sort; in_stall_o then stays high until
// the final sorted record has been loaded into the output register.
// Output channel: one transaction per stored record, in stable sorted order under
// sort_mode; out_last marks the final record and overflow_flag is set on every
// record of a batch that exceeded MAX_RECORDS (the extra records are dropped).
// Configuration: cfg_we_i writes sort_mode from cfg_wdata_i; the new mode applies
// from the cycle after the write. Ranking is bound by the single read port of the
// record store (one compare per cycle); each sorted record is then emitted through
// ST_O_RD, ST_O_REC and ST_O_LD in turn, the next one fetched only after it is loaded.
// A stall holds the output register; the next record is fetched behind it and waits.
// Loading of the next batch begins while the final result still waits.
// Reset empties the store, clears the overflow mark, sets sort_mode to back to
// front and drops any pending output.
module depth_or_texture_stable_sorter import dots_pkg::*; #(
  parameter int MAX_RECORDS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o
);

  localparam int IW = $clog2(MAX_RECORDS);

  cmd_t          cmd;
  sts_t          sts;
  logic [IW-1:0] addr;
  logic [IW-1:0] cur_idx;

  dots_ctrl #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_data_i.batch_last),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .addr_o    (addr),
    .cur_idx_o (cur_idx)
  );

  dots_dpath #(
    .MAX_RECORDS(MAX_RECORDS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .cur_idx_i  (cur_idx),
    .sts_o      (sts),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== rtl/core/dots_checker.sv =====
// Port-level checker of the stable sprite sorter and its bind.
module dots_checker import dots_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input in_t  in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output transaction changed");

  a_sort_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.batch_last |=> in_stall_o)
    else $error("input not held after final record of a batch");

  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |-> in_stall_o)
    else $error("input taken while a batch is still being emitted");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output transaction right after reset");

endmodule

bind depth_or_texture_stable_sorter dots_checker u_dots_checker (.*);
